// ===== rtl/lppc_pkg.sv =====
// ----------------------------------------------------------------------------
// lppc_pkg
// shared types and constants of the lidar point projection and colour map
// ----------------------------------------------------------------------------
`default_nettype none

package lppc_pkg;

  // configuration register indexes
  localparam logic [2:0] CfgFocalX    = 3'd0;
  localparam logic [2:0] CfgFocalY    = 3'd1;
  localparam logic [2:0] CfgCenterX   = 3'd2;
  localparam logic [2:0] CfgCenterY   = 3'd3;
  localparam logic [2:0] CfgImgWidth  = 3'd4;
  localparam logic [2:0] CfgImgHeight = 3'd5;
  localparam logic [2:0] CfgRangeLim  = 3'd6;
  localparam logic [2:0] CfgDrawLim   = 3'd7;

  // iteration counts of the shared unit
  localparam logic [6:0] DivSteps  = 7'd64;
  localparam logic [6:0] SqrtSteps = 7'd32;

  // hue constants, 16 fraction bits
  localparam logic [31:0] HueScale    = 32'd15728640;  // 240 * 65536
  localparam logic [23:0] SectorLen   = 24'd3932160;   // 60 * 65536
  // ceil(2^24 / 15): exact quotient by 15 for dividends below 2^20
  localparam logic [31:0] SectorRecip = 32'd1118482;
  localparam logic [16:0] HueFull     = 17'h10000;
  localparam logic [13:0] MaxImg      = 14'd8192;

  typedef enum logic [1:0] {
    OP_DIV  = 2'b01,
    OP_SQRT = 2'b10
  } iter_op_e;

  typedef struct packed {
    logic        start;
    iter_op_e    op;
    logic [63:0] opa;
    logic [31:0] opb;
  } iter_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] res;
  } iter_sts_t;

  // (c * 255) >> 16 for c in 0..65536
  function automatic logic [7:0] to_byte(input logic [16:0] c);
    logic [24:0] t;
    t = {c, 8'd0} - {8'd0, c};
    return t[23:16];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lppc_in_if.sv =====
// ----------------------------------------------------------------------------
// lppc_in_if
// point channel: command and camera-frame coordinates
// ----------------------------------------------------------------------------
`default_nettype none

interface lppc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;

  modport source (output valid, cmd, point_x, point_y, point_z, input ready);
  modport sink   (input valid, cmd, point_x, point_y, point_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/lppc_out_if.sv =====
// ----------------------------------------------------------------------------
// lppc_out_if
// pixel channel: image position and colour bytes
// ----------------------------------------------------------------------------
`default_nettype none

interface lppc_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] pixel_u;
  logic [12:0] pixel_v;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  modport source (output valid, pixel_u, pixel_v, red, green, blue, input ready);
  modport sink   (input valid, pixel_u, pixel_v, red, green, blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/lppc_iter.sv =====
// ----------------------------------------------------------------------------
// lppc_iter
// shared bit-serial unit: 64/32 restoring divide or 64-bit integer square root
// ----------------------------------------------------------------------------
`default_nettype none

module lppc_iter import lppc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire iter_req_t req_i,
  output iter_sts_t      sts_o
);

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  iter_op_e    op_q;
  logic [63:0] a_q, res_q, bit_q;
  logic [31:0] b_q;
  logic [32:0] rem_q;

  logic [32:0] rem_sh, rem_nx;
  logic        dv_ge, sq_ge;
  logic [63:0] trial;

  assign rem_sh = {rem_q[31:0], a_q[63]};
  assign dv_ge  = rem_sh >= {1'b0, b_q};
  assign rem_nx = dv_ge ? rem_sh - {1'b0, b_q} : rem_sh;
  assign trial  = res_q + bit_q;
  assign sq_ge  = a_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_DIV;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= (req_i.op == OP_DIV) ? DivSteps : SqrtSteps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.opa;
      b_q   <= req_i.opb;
      rem_q <= '0;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      unique case (op_q)
        OP_DIV: begin
          a_q   <= {a_q[62:0], 1'b0};
          rem_q <= rem_nx;
          res_q <= {res_q[62:0], dv_ge};
        end
        OP_SQRT: begin
          if (sq_ge) begin
            a_q   <= a_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
        default: begin
          res_q <= res_q;
        end
      endcase
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign sts_o.res  = res_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("start while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without work");
  a_sqrt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && op_q == OP_SQRT) |-> cnt_q <= SqrtSteps) else $error("sqrt count");

endmodule

`default_nettype wire

// ===== rtl/lidar_point_projection_colormap.sv =====
// ----------------------------------------------------------------------------
// lidar_point_projection_colormap
// pinhole projection of camera-frame points with a distance hue colour map
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  in_s      in   valid / ready    cmd, point_x, point_y, point_z
//  out_m     out  valid / ready    pixel_u, pixel_v, red, green, blue
//  cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i
//
// a statistics point runs two squares on the multiplier, then the 32-step
// square root on the shared unit
// a drawn projection point runs three 64-step divides and one square root on
// the shared unit, the sector split is a reciprocal multiply;
// a black pixel skips the hue divide
// reset: async active low; min/max back to all ones / zero, statistics pass
// a finished pixel waits in the output register; a new point is taken then,
// and the sequencer stalls only when a second pixel is ready to go out
`default_nettype none

module lidar_point_projection_colormap import lppc_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lppc_in_if.sink          in_s,
  lppc_out_if.source       out_m,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_CHK  = 19'h00002,
    S_SQA  = 19'h00004,
    S_SQB  = 19'h00008,
    S_SQS  = 19'h00010,
    S_WSQ  = 19'h00020,
    S_PMU  = 19'h00040,
    S_PDU  = 19'h00080,
    S_WDU  = 19'h00100,
    S_PMV  = 19'h00200,
    S_PDV  = 19'h00400,
    S_WDV  = 19'h00800,
    S_COL  = 19'h01000,
    S_CMU  = 19'h02000,
    S_CDV  = 19'h04000,
    S_WCD  = 19'h08000,
    S_RDV  = 19'h10000,
    S_WRD  = 19'h20000,
    S_EMIT = 19'h40000
  } state_e;

  localparam logic [31:0] FarDefault = 32'(120 << FracBits);

  // configuration
  logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [13:0] img_w_q, img_h_q;
  logic [31:0] range_lim_q, draw_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q   <= 32'd156007530;
      focal_y_q   <= 32'd156059763;
      center_x_q  <= 32'd67946807;
      center_y_q  <= 32'd50282365;
      img_w_q     <= 14'd2048;
      img_h_q     <= 14'd1536;
      range_lim_q <= 32'd1966080;
      draw_lim_q  <= 32'd786432;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFocalX:    focal_x_q   <= cfg_data_i;
        CfgFocalY:    focal_y_q   <= cfg_data_i;
        CfgCenterX:   center_x_q  <= cfg_data_i;
        CfgCenterY:   center_y_q  <= cfg_data_i;
        CfgImgWidth:  img_w_q     <= cfg_data_i[13:0];
        CfgImgHeight: img_h_q     <= cfg_data_i[13:0];
        CfgRangeLim:  range_lim_q <= cfg_data_i;
        CfgDrawLim:   draw_lim_q  <= cfg_data_i;
        default:      focal_x_q   <= focal_x_q;
      endcase
    end
  end

  // control state
  state_e      state_q, state_d;
  logic        in_proj_q;
  logic [31:0] near_q, far_q;
  logic        out_valid_q;

  // payload
  logic        cmd_q;
  logic [31:0] x_q, y_q, z_q;
  logic [63:0] prod_q, sum_q;
  logic [31:0] d_q;
  logic [12:0] u_q, v_q;
  logic [23:0] h16_q;
  logic [1:0]  sector_q;
  logic [7:0]  r_q, g_q, b_q;
  logic [12:0] out_u_q, out_v_q;
  logic [7:0]  out_r_q, out_g_q, out_b_q;

  iter_req_t   ireq;
  iter_sts_t   ists;

  lppc_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ireq),
    .sts_o  (ists)
  );

  // magnitudes
  logic [31:0] mx, my, mz;
  assign mx = x_q[31] ? (~x_q + 32'd1) : x_q;
  assign my = y_q[31] ? (~y_q + 32'd1) : y_q;
  assign mz = z_q[31] ? (~z_q + 32'd1) : z_q;

  logic z_pos;
  assign z_pos = !z_q[31] && (z_q != 32'd0);

  // colour helpers
  logic [31:0] span, off;
  logic        black;
  assign span  = far_q - near_q;
  assign off   = (d_q > near_q) ? d_q - near_q : 32'd0;
  assign black = off >= span;

  logic [1:0]  sector;
  logic [23:0] sec_base;
  always_comb begin
    if (h16_q >= 24'(3 * SectorLen)) begin
      sector   = 2'd3;
      sec_base = 24'(3 * SectorLen);
    end else if (h16_q >= 24'(2 * SectorLen)) begin
      sector   = 2'd2;
      sec_base = 24'(2 * SectorLen);
    end else if (h16_q >= SectorLen) begin
      sector   = 2'd1;
      sec_base = SectorLen;
    end else begin
      sector   = 2'd0;
      sec_base = '0;
    end
  end

  // position inside the sector, below 60 * 65536
  logic [23:0] sec_rem;
  assign sec_rem = h16_q - sec_base;

  // shared multiplier, one product per cycle, registered
  logic [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = mx;
    mul_b = mx;
    priority case (1'b1)
      state_q == S_SQB: begin
        mul_a = cmd_q ? mz : my;
        mul_b = cmd_q ? mz : my;
      end
      state_q == S_PMU: begin
        mul_a = focal_x_q;
      end
      state_q == S_PMV: begin
        mul_a = focal_y_q;
        mul_b = my;
      end
      state_q == S_CMU: begin
        mul_a = off;
        mul_b = HueScale;
      end
      // divide by 60 as a quarter, then a reciprocal multiply by 1/15
      state_q == S_RDV: begin
        mul_a = {12'd0, sec_rem[21:2]};
        mul_b = SectorRecip;
      end
      default: begin
        mul_a = mx;
      end
    endcase
  end

  // projection check of one axis: -1 < s < limit, in fixed point
  logic                sel_v, p_neg;
  logic [31:0]         cen;
  logic [13:0]         lim_raw, lim_c;
  logic [62:0]         q_sat;
  logic signed [64:0]  s_fix, lim_fix, neg_one;
  logic                in_rng;
  logic [12:0]         coord;

  assign sel_v   = (state_q == S_WDV);
  assign p_neg   = sel_v ? y_q[31] : x_q[31];
  assign cen     = sel_v ? center_y_q : center_x_q;
  assign lim_raw = sel_v ? img_h_q : img_w_q;
  assign lim_c   = (lim_raw > MaxImg) ? MaxImg : lim_raw;
  assign q_sat   = (ists.res > 64'h4000_0000_0000_0000) ? 63'h4000_0000_0000_0000
                                                       : ists.res[62:0];
  assign s_fix   = p_neg ? ($signed({33'd0, cen}) - $signed({2'd0, q_sat}))
                         : ($signed({33'd0, cen}) + $signed({2'd0, q_sat}));
  assign lim_fix = $signed({51'd0, lim_c}) <<< FracBits;
  assign neg_one = -($signed(65'd1) <<< FracBits);
  assign in_rng  = (s_fix > neg_one) && (s_fix < lim_fix);
  assign coord   = (s_fix > 65'sd0) ? s_fix[FracBits +: 13] : 13'd0;

  logic [16:0] rise, fall;
  assign rise = prod_q[40:24];
  assign fall = HueFull - rise;

  // request to the shared unit
  always_comb begin
    ireq.start = 1'b0;
    ireq.op    = OP_DIV;
    ireq.opa   = prod_q;
    ireq.opb   = z_q;
    priority case (1'b1)
      state_q == S_SQS: begin
        ireq.start = 1'b1;
        ireq.op    = OP_SQRT;
        ireq.opa   = sum_q + prod_q;
      end
      state_q == S_PDU || state_q == S_PDV: begin
        ireq.start = 1'b1;
      end
      state_q == S_CDV: begin
        ireq.start = 1'b1;
        ireq.opb   = span;
      end
      default: begin
        ireq.start = 1'b0;
      end
    endcase
  end

  // sequencer
  logic out_free;
  assign out_free   = !out_valid_q || out_m.ready;
  assign in_s.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_s.valid) state_d = S_CHK;
      S_CHK: begin
        if (!cmd_q) begin
          state_d = (z_pos && z_q <= range_lim_q) ? S_SQA : S_IDLE;
        end else begin
          state_d = (z_pos && z_q <= draw_lim_q) ? S_PMU : S_IDLE;
        end
      end
      S_SQA:  state_d = S_SQB;
      S_SQB:  state_d = S_SQS;
      S_SQS:  state_d = S_WSQ;
      S_WSQ:  if (ists.done) state_d = cmd_q ? S_COL : S_IDLE;
      S_PMU:  state_d = S_PDU;
      S_PDU:  state_d = S_WDU;
      S_WDU:  if (ists.done) state_d = in_rng ? S_PMV : S_IDLE;
      S_PMV:  state_d = S_PDV;
      S_PDV:  state_d = S_WDV;
      S_WDV:  if (ists.done) state_d = in_rng ? S_SQA : S_IDLE;
      S_COL:  state_d = black ? S_EMIT : S_CMU;
      S_CMU:  state_d = S_CDV;
      S_CDV:  state_d = S_WCD;
      S_WCD:  if (ists.done) state_d = S_RDV;
      S_RDV:  state_d = S_WRD;
      S_WRD:  state_d = S_EMIT;
      S_EMIT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_proj_q   <= 1'b0;
      near_q      <= '1;
      far_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // pass switch and range freeze happen whether or not the point counts
      if (state_q == S_CHK) begin
        if (!cmd_q && in_proj_q) begin
          in_proj_q <= 1'b0;
          near_q    <= '1;
          far_q     <= '0;
        end else if (cmd_q && !in_proj_q) begin
          in_proj_q <= 1'b1;
          if (far_q <= near_q) begin
            near_q <= '0;
            far_q  <= FarDefault;
          end
        end
      end
      if (state_q == S_WSQ && ists.done && !cmd_q) begin
        if (ists.res[31:0] < near_q) near_q <= ists.res[31:0];
        if (ists.res[31:0] > far_q)  far_q  <= ists.res[31:0];
      end
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_m.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.valid && in_s.ready) begin
      cmd_q <= in_s.cmd;
      x_q   <= in_s.point_x;
      y_q   <= in_s.point_y;
      z_q   <= in_s.point_z;
    end
    prod_q <= mul_a * mul_b;
    if (state_q == S_SQB) sum_q <= prod_q;
    if (state_q == S_WSQ && ists.done) d_q <= ists.res[31:0];
    if (state_q == S_WDU && ists.done) u_q <= coord;
    if (state_q == S_WDV && ists.done) v_q <= coord;
    if (state_q == S_COL && black) begin
      r_q <= '0;
      g_q <= '0;
      b_q <= '0;
    end
    if (state_q == S_WCD && ists.done) h16_q <= ists.res[23:0];
    if (state_q == S_RDV) sector_q <= sector;
    if (state_q == S_WRD) begin
      unique case (sector_q)
        2'd0: begin
          r_q <= to_byte(HueFull); g_q <= to_byte(rise); b_q <= '0;
        end
        2'd1: begin
          r_q <= to_byte(fall); g_q <= to_byte(HueFull); b_q <= '0;
        end
        2'd2: begin
          r_q <= '0; g_q <= to_byte(HueFull); b_q <= to_byte(rise);
        end
        default: begin
          r_q <= '0; g_q <= to_byte(fall); b_q <= to_byte(HueFull);
        end
      endcase
    end
    if (state_q == S_EMIT && out_free) begin
      out_u_q <= u_q;
      out_v_q <= v_q;
      out_r_q <= r_q;
      out_g_q <= g_q;
      out_b_q <= b_q;
    end
  end

  assign out_m.valid   = out_valid_q;
  assign out_m.pixel_u = out_u_q;
  assign out_m.pixel_v = out_v_q;
  assign out_m.red     = out_r_q;
  assign out_m.green   = out_g_q;
  assign out_m.blue    = out_b_q;

  // the frozen range always has a positive span
  a_span_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_proj_q |-> far_q > near_q) else $error("empty range in projection pass");
  // pixels come only out of the projection pass
  a_emit_proj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> in_proj_q && cmd_q) else $error("pixel outside projection");
  // a new output only after the emit state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT)) else $error("stray output");
  // the shared unit finishes only while the sequencer waits for it
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ists.done |-> (state_q == S_WSQ || state_q == S_WDU || state_q == S_WDV ||
                   state_q == S_WCD)) else $error("unexpected done");

endmodule

`default_nettype wire

// ===== tb/lppc_tb_if.sv =====
// ----------------------------------------------------------------------------
// lppc_tb_if
// testbench side of the point and pixel channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// the channel interfaces come from the rtl folder; this file only keeps the
// per-file layout of the project and adds a helper record for expected pixels
package lppc_tb_pkg;
  typedef struct packed {
    logic [12:0] pixel_u;
    logic [12:0] pixel_v;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_t;
endpackage

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking regression of the lidar projection and colour map: a model of
// the projection, statistics and hue ramp predicts each pixel, results are
// compared in order while both channels idle and stall at random
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lppc_pkg::*;
  import lppc_tb_pkg::*;

  localparam int unsigned Frac = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = CfgFocalX;
  logic [31:0] cfg_data_i = '0;

  lppc_in_if in_ch();
  lppc_out_if out_ch();

  lidar_point_projection_colormap #(.FracBits(Frac)) DUT (
    .clk_i, .rst_ni, .in_s(in_ch.sink), .out_m(out_ch.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // model copy of the registers and statistics
  logic [31:0] fx_q, fy_q, cx_q, cy_q, rlim_q, dlim_q;
  logic [13:0] w_q, h_q;
  logic        proj_pass;
  logic [31:0] near_d, far_d;

  pixel_t pixel_q[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     rx_hold = 1'b0;   // long receiver hold-off
  bit     rx_random = 1'b1;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // idle watchdog: nothing accepted for too long ends the run
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 20000) begin
      $display("lidar_point_projection_colormap regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model
  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] hyp(input logic signed [31:0] a,
                                      input logic signed [31:0] b);
    logic [63:0] ma, mb, d;
    ma = a < 0 ? 64'(-64'(a)) : 64'(a);
    mb = b < 0 ? 64'(-64'(b)) : 64'(b);
    d = isqrt(ma * ma + mb * mb);
    return d > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : d[31:0];
  endfunction

  // one axis; returns 1 when -1 < s < lim, in fixed point
  function automatic bit axis(input logic [31:0] f, input logic [31:0] c,
                              input logic signed [31:0] p,
                              input logic signed [31:0] z,
                              input logic [13:0] lim_in, output logic [12:0] co);
    logic [63:0] mp, q;
    longint s, lim;
    mp = p < 0 ? 64'(-64'(p)) : 64'(p);
    q = (64'(f) * mp) / 64'(z);
    lim = lim_in > MaxImg ? 8192 : longint'(lim_in);
    if (q > (64'd1 << 62)) q = 64'd1 << 62;
    s = p < 0 ? longint'(c) - longint'(q) : longint'(c) + longint'(q);
    co = '0;
    if (s <= -(longint'(1) << Frac) || s >= (lim << Frac)) return 1'b0;
    co = s > 0 ? 13'(s >> Frac) : '0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] byte_of(input logic [63:0] c);
    logic [63:0] t;
    t = (c * 255) >> 16;
    return t[7:0];
  endfunction

  // updates model state; returns 1 with a pixel when one is produced
  function automatic bit predict_pixel(input logic cmd, input logic signed [31:0] x,
                                       input logic signed [31:0] y,
                                       input logic signed [31:0] z,
                                       output pixel_t px);
    logic [31:0] d;
    logic [63:0] span, off, h16, sec, rise, fall;
    logic [12:0] u, v;
    px = '0;
    if (!cmd) begin
      if (proj_pass) begin
        proj_pass = 1'b0;
        near_d = '1;
        far_d = '0;
      end
      if (z <= 0 || 32'(z) > rlim_q) return 1'b0;
      d = hyp(x, y);
      if (d < near_d) near_d = d;
      if (d > far_d) far_d = d;
      return 1'b0;
    end
    if (!proj_pass) begin
      proj_pass = 1'b1;
      if (far_d <= near_d) begin
        near_d = 0;
        far_d = 32'(120) << Frac;
      end
    end
    if (z <= 0 || 32'(z) > dlim_q) return 1'b0;
    if (!axis(fx_q, cx_q, x, z, w_q, u)) return 1'b0;
    if (!axis(fy_q, cy_q, y, z, h_q, v)) return 1'b0;
    d = hyp(x, z);
    span = 64'(far_d) - 64'(near_d);
    off = d > near_d ? 64'(d) - 64'(near_d) : 0;
    if (far_d <= near_d || off >= span) h16 = 240 * 65536;
    else h16 = off * 240 * 65536 / span;
    px.pixel_u = u;
    px.pixel_v = v;
    if (h16 < 240 * 65536) begin
      sec = h16 / (60 * 65536);
      rise = (h16 - sec * 60 * 65536) / 60;
      fall = 65536 - rise;
      case (sec)
        0: begin px.red = byte_of(65536); px.green = byte_of(rise); end
        1: begin px.red = byte_of(fall); px.green = byte_of(65536); end
        2: begin px.green = byte_of(65536); px.blue = byte_of(rise); end
        default: begin px.green = byte_of(fall); px.blue = byte_of(65536); end
      endcase
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected pixel", out_ch.pixel_u, 0);
      end else begin
        want = pixel_q.pop_front();
        if (out_ch.pixel_u !== want.pixel_u) report_mismatch("u", out_ch.pixel_u, want.pixel_u);
        if (out_ch.pixel_v !== want.pixel_v) report_mismatch("v", out_ch.pixel_v, want.pixel_v);
        if (out_ch.red !== want.red) report_mismatch("red", out_ch.red, want.red);
        if (out_ch.green !== want.green) report_mismatch("green", out_ch.green, want.green);
        if (out_ch.blue !== want.blue) report_mismatch("blue", out_ch.blue, want.blue);
      end
    end
  end

  // receiver stall pattern, plus the long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold) begin
      out_ch.ready <= 1'b0;
    end else if (rx_random) begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  int burst_left = 0;

  // sends one point and records its expected pixel at acceptance
  task automatic send_point(input logic cmd, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z);
    pixel_t px;
    int     gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 40) : 0;
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.point_z <= z;
    do @(posedge clk_i); while (!in_ch.ready);
    if (predict_pixel(cmd, x, y, z, px)) pixel_q = {pixel_q, px};
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgFocalX:    fx_q = val;
      CfgFocalY:    fy_q = val;
      CfgCenterX:   cx_q = val;
      CfgCenterY:   cy_q = val;
      CfgImgWidth:  w_q = val[13:0];
      CfgImgHeight: h_q = val[13:0];
      CfgRangeLim:  rlim_q = val;
      default:      dlim_q = val;
    endcase
  endtask

  // coordinate with a mix of small, metre-scale and extreme values
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_depth(input logic [31:0] lim);
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'($signed(0) - $signed($urandom_range(0, 100)));
      2: return lim;
      default: return lim == 0 ? 0 : $urandom_range(1, lim);
    endcase
  endfunction

  task automatic test_directed();
    // no statistics: default range, then the far-colour and edge cases
    send_point(1'b1, 0, 0, 1 << 16);
    send_point(1'b1, 32'h7FFF_FFFF, 0, 1 << 16);
    send_point(1'b1, 32'h8000_0000, 32'h8000_0000, 1 << 16);
    send_point(1'b1, 0, 0, 0);
    send_point(1'b1, 0, 0, 32'hFFFF_0000);
    send_point(1'b1, 0, 0, dlim_q);
    send_point(1'b1, 0, 0, dlim_q + 1);
    // a real cloud: statistics then projection
    send_point(1'b0, 1 << 16, 0, 1 << 16);
    send_point(1'b0, 5 << 16, 3 << 16, 2 << 16);
    send_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 1 << 16);
    send_point(1'b0, 0, 0, rlim_q + 1);
    send_point(1'b0, 0, 0, 32'h8000_0000);
    for (int i = 0; i < 10; i++) begin
      send_point(1'b1, 32'(i - 5) << 15, 32'(i - 4) << 15, 32'(i + 1) << 16);
    end
    // equal min and max falls back to the default range
    send_point(1'b0, 2 << 16, 0, 1 << 16);
    send_point(1'b1, 0, 0, 2 << 16);
    drain();
  endtask

  task automatic run_cloud(input int n);
    int ns;
    ns = $urandom_range(0, 1) ? $urandom_range(1, n / 2) : $urandom_range(0, 3);
    for (int i = 0; i < ns; i++)
      send_point(1'b0, rand_coord(), rand_coord(), rand_depth(rlim_q));
    for (int i = ns; i < n; i++)
      send_point($urandom_range(0, 19) != 0, rand_coord(), rand_coord(),
                 rand_depth(dlim_q));
  endtask

  task automatic test_random(input int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      int n;
      n = $urandom_range(4, 40);
      run_cloud(n);
      sent += n;
    end
    drain();
  endtask

  task automatic test_config_sweep();
    // extremes of every register, then a random mix
    write_reg(CfgFocalX, 32'hFFFF_FFFF);
    write_reg(CfgFocalY, 0);
    write_reg(CfgCenterX, 0);
    write_reg(CfgCenterY, 32'hFFFF_FFFF);
    write_reg(CfgImgWidth, 32'h3FFF);
    write_reg(CfgImgHeight, 1);
    write_reg(CfgRangeLim, 32'hFFFF_FFFF);
    write_reg(CfgDrawLim, 32'hFFFF_FFFF);
    test_random(150);
    write_reg(CfgFocalX, 0);
    write_reg(CfgFocalY, 32'hFFFF_FFFF);
    write_reg(CfgCenterX, 32'hFFFF_FFFF);
    write_reg(CfgCenterY, 0);
    write_reg(CfgImgWidth, 0);
    write_reg(CfgImgHeight, 8192);
    write_reg(CfgRangeLim, 0);
    write_reg(CfgDrawLim, 0);
    test_random(100);
    write_reg(CfgImgWidth, 1);
    write_reg(CfgImgHeight, 32'h3FFF);
    write_reg(CfgDrawLim, 32'hFFFF_FFFF);
    write_reg(CfgRangeLim, 32'h7FFF_FFFF);
    test_random(100);
    for (int k = 0; k < 4; k++) begin
      write_reg(CfgFocalX, $urandom_range(200 << 16, 2000 << 16));
      write_reg(CfgFocalY, $urandom_range(200 << 16, 2000 << 16));
      write_reg(CfgCenterX, $urandom_range(0, 2000 << 16));
      write_reg(CfgCenterY, $urandom_range(0, 2000 << 16));
      write_reg(CfgImgWidth, $urandom_range(1, 8192));
      write_reg(CfgImgHeight, $urandom_range(1, 8192));
      write_reg(CfgRangeLim, $urandom_range(1 << 16, 60 << 16));
      write_reg(CfgDrawLim, $urandom_range(1 << 16, 60 << 16));
      test_random(150);
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off for a long stretch while points keep coming
    fork
      begin
        rx_hold = 1'b1;
        repeat (3000) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 30; i++) send_point(1'b1, 0, 0, 1 << 16);
    join
    drain();
    rx_random = 1'b0;
    test_random(100);
    rx_random = 1'b1;
  endtask

  initial begin
    fx_q = 32'd156007530;  fy_q = 32'd156059763;
    cx_q = 32'd67946807;   cy_q = 32'd50282365;
    w_q = 14'd2048;        h_q = 14'd1536;
    rlim_q = 32'd1966080;  dlim_q = 32'd786432;
    proj_pass = 1'b0;      near_d = '1;  far_d = '0;
    in_ch.valid = 1'b0;    in_ch.cmd = 1'b0;
    in_ch.point_x = '0;    in_ch.point_y = '0;  in_ch.point_z = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500);
    test_backpressure();
    test_config_sweep();
    if (errors == 0) begin
      $display("lidar_point_projection_colormap regression: pass");
    end else begin
      $display("lidar_point_projection_colormap regression: fail");
    end
    $finish;
  end

endmodule
